[hw/rtl/dotq_pkg.sv]
package dotq_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned DelayW = 24;
  localparam int unsigned IdW    = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StatW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   id;
  } entry_t;

  typedef struct packed {
    cell_op_e         op;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] delay;
    logic [TimeW-1:0] new_deadline;
    logic [IdW-1:0]   new_id;
    logic [IdW-1:0]   tid;
  } cell_ctrl_t;

  typedef struct packed {
    status_e           status;
    logic [IdW-1:0]    event_id;
    logic              expired;
    logic [DelayW-1:0] wait_ms;
    logic              none_pending;
    logic              last;
  } result_t;

endpackage

[hw/rtl/dotq_if.sv]
interface dotq_cmd_if;
  import dotq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [DelayW-1:0] delay_ms;
  logic [IdW-1:0]    target_id;

  modport source (output valid, command, delay_ms, target_id, input ready);
  modport sink (input valid, command, delay_ms, target_id, output ready);
endinterface

interface dotq_res_if;
  import dotq_pkg::*;

  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic [IdW-1:0]    event_id;
  logic              expired;
  logic [DelayW-1:0] wait_ms;
  logic              none_pending;
  logic              last;

  modport source (output valid, status, event_id, expired, wait_ms, none_pending, last,
                  input ready);
  modport sink (input valid, status, event_id, expired, wait_ms, none_pending, last,
                output ready);
endinterface

[hw/rtl/dotq_cell.sv]
module dotq_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dotq_pkg::cell_ctrl_t ctrl_i,
  input  dotq_pkg::entry_t     left_i,
  input  logic                 left_keep_i,
  input  dotq_pkg::entry_t     right_i,
  input  logic                 hit_i,
  output logic                 keep_o,
  output logic                 hit_o,
  output dotq_pkg::entry_t     entry_o
);
  import dotq_pkg::*;

  logic             valid_q, valid_d;
  logic [TimeW-1:0] dl_q, dl_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [TimeW-1:0] dl_gap;
  logic             match;

  always_comb begin
    dl_gap = dl_q - ctrl_i.now;
    keep_o = valid_q && (dl_gap <= ctrl_i.delay);
    match  = valid_q && (id_q == ctrl_i.tid);
    hit_o  = hit_i | match;
  end

  always_comb begin
    valid_d = valid_q;
    dl_d    = dl_q;
    id_d    = id_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            // new event lands here, everything behind moves one cell back
            valid_d = 1'b1;
            dl_d    = ctrl_i.new_deadline;
            id_d    = ctrl_i.new_id;
          end else begin
            valid_d = left_i.valid;
            dl_d    = left_i.deadline;
            id_d    = left_i.id;
          end
        end
      end
      CELL_REMOVE: begin
        if (hit_o) begin
          valid_d = right_i.valid;
          dl_d    = right_i.deadline;
          id_d    = right_i.id;
        end
      end
      CELL_POP: begin
        valid_d = right_i.valid;
        dl_d    = right_i.deadline;
        id_d    = right_i.id;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q <= dl_d;
    id_q <= id_d;
  end

  assign entry_o = '{valid: valid_q, deadline: dl_q, id: id_q};

endmodule

[hw/rtl/deadline_ordered_timer_event_queue_core.sv]
// Timer event queue kept in deadline order in a row of cells.
// in_i carries one command per item: add (delay_ms ticks from now), remove by
// target_id, tick (advance the internal clock by one) or nop. out_o returns the
// results of each item with valid/ready; the final result of an item has
// last set and gives the wait until the earliest deadline or none_pending.
// Add, remove and nop give one result; a tick gives one result per expired event,
// earliest first, then the summary.
// An accepted item passes through S_EXEC and S_CHECK; out_o is valid in S_OUT.
// One item is handled at a time; a tick that expires events loops through S_CHECK
// and S_OUT once per expired event, popping the head cell and checking the next.
// in_i.ready is high only while no item is in flight.
// When out_o.ready is low the result is held in the output register and the
// block waits; nothing is dropped.
// Reset empties the table and clears the clock and the id counter; the first
// id issued is 1.
module deadline_ordered_timer_event_queue_core #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned DELAY_BITS  = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  dotq_cmd_if.sink   in_i,
  dotq_res_if.source out_o
);
  import dotq_pkg::*;

  localparam logic [TimeW-1:0] DelayMask = (TimeW'(1) << DELAY_BITS) - TimeW'(1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_CHECK = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  cmd_e             cmd_q;
  logic [TimeW-1:0] delay_q;
  logic [IdW-1:0]   tid_q;
  logic [TimeW-1:0] now_q, now_d;
  logic [IdW-1:0]   next_id_q, next_id_d;
  status_e          status_q, status_d;
  logic [IdW-1:0]   evid_q, evid_d;
  result_t          out_q, out_d;

  cell_ctrl_t             ctrl;
  entry_t                 entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] keep;
  logic [TABLE_DEPTH-1:0] hit;
  logic [TABLE_DEPTH-1:0] vld;

  logic             accept;
  logic             full;
  logic             found;
  logic             add_ok;
  logic [TimeW-1:0] head_dist;
  logic             head_expired;
  logic             expire;
  logic [DelayW-1:0] head_wait;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign full   = entries[TABLE_DEPTH-1].valid;
  assign found  = hit[TABLE_DEPTH-1];
  assign add_ok = (cmd_q == CMD_ADD) && (delay_q != '0) && !full;

  assign head_dist    = entries[0].deadline - now_q;
  assign head_expired = entries[0].valid && ((head_dist == '0) || head_dist[TimeW-1]);
  assign expire       = (cmd_q == CMD_TICK) && head_expired;
  assign head_wait    = (|head_dist[TimeW-1:DelayW]) ? '1 : head_dist[DelayW-1:0];

  always_comb begin
    ctrl.now          = now_q;
    ctrl.delay        = delay_q;
    ctrl.new_deadline = now_q + delay_q;
    ctrl.new_id       = next_id_q + IdW'(1);
    ctrl.tid          = tid_q;
    ctrl.op           = CELL_HOLD;
    if (state_q == S_EXEC) begin
      if (add_ok) begin
        ctrl.op = CELL_INSERT;
      end else if (cmd_q == CMD_REMOVE) begin
        ctrl.op = CELL_REMOVE;
      end
    end else if ((state_q == S_CHECK) && expire) begin
      ctrl.op = CELL_POP;
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t left;
    entry_t right;
    logic   left_keep;
    logic   hit_in;

    if (g == 0) begin : g_head
      assign left      = '0;
      assign left_keep = 1'b1;
      assign hit_in    = 1'b0;
    end else begin : g_body
      assign left      = entries[g-1];
      assign left_keep = keep[g-1];
      assign hit_in    = hit[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = entries[g+1];
    end

    dotq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .hit_i       (hit_in),
      .keep_o      (keep[g]),
      .hit_o       (hit[g]),
      .entry_o     (entries[g])
    );

    assign vld[g] = entries[g].valid;
  end

  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    next_id_d = next_id_q;
    status_d  = status_q;
    evid_d    = evid_q;
    out_d     = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        evid_d   = '0;
        case (cmd_q)
          CMD_ADD: begin
            if (delay_q == '0) begin
              status_d = ST_INVALID;
            end else if (full) begin
              status_d = ST_FULL;
            end else begin
              next_id_d = next_id_q + IdW'(1);
              evid_d    = next_id_q + IdW'(1);
            end
          end
          CMD_REMOVE: begin
            status_d = found ? ST_OK : ST_NOT_FOUND;
            evid_d   = tid_q;
          end
          CMD_TICK: begin
            now_d = now_q + TimeW'(1);
          end
          default: begin
          end
        endcase
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (expire) begin
          out_d = '{status: ST_OK, event_id: entries[0].id, expired: 1'b1,
                    wait_ms: '0, none_pending: 1'b0, last: 1'b0};
        end else begin
          out_d = '{status: status_q, event_id: evid_q, expired: 1'b0,
                    wait_ms: entries[0].valid ? head_wait : '0,
                    none_pending: !entries[0].valid, last: 1'b1};
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = out_q.last ? S_IDLE : S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      now_q     <= '0;
      next_id_q <= '0;
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      next_id_q <= next_id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(in_i.command);
      delay_q <= {{(TimeW-DelayW){1'b0}}, in_i.delay_ms} & DelayMask;
      tid_q   <= in_i.target_id;
    end
    status_q <= status_d;
    evid_q   <= evid_d;
    out_q    <= out_d;
  end

  assign out_o.valid        = (state_q == S_OUT);
  assign out_o.status       = out_q.status;
  assign out_o.event_id     = out_q.event_id;
  assign out_o.expired      = out_q.expired;
  assign out_o.wait_ms      = out_q.wait_ms;
  assign out_o.none_pending = out_q.none_pending;
  assign out_o.last         = out_q.last;

`ifndef NO_ASSERTIONS
  // valid entries always sit packed at the head of the row
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld + TABLE_DEPTH'(1)) & vld) == '0)
    else $error("table not packed");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == CELL_INSERT) |=> ($countones(vld) == $past($countones(vld)) + 1))
    else $error("insert did not add one entry");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == CELL_REMOVE && found) |=>
      ($countones(vld) == $past($countones(vld)) - 1))
    else $error("remove did not drop one entry");

  // between items no pending event may already be due
  a_idle_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !head_expired)
    else $error("expired event left in table");

  a_expiry_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_q.expired) |-> !out_q.last)
    else $error("expiry result marked last");
`endif

endmodule

[test/tb_deadline_ordered_timer_event_queue_core.sv]
`timescale 1ns / 1ps

module tb_deadline_ordered_timer_event_queue_core;
  import dotq_pkg::*;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned DelayBits  = 24;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned WatchLimit = 2000;
  localparam logic [TimeW-1:0] WaitMax = 32'h00FF_FFFF;

  typedef struct {
    cmd_e              command;
    logic [DelayW-1:0] delay_ms;
    logic [IdW-1:0]    target_id;
  } timer_cmd_t;

  logic clk_i;
  logic rst_ni;

  dotq_cmd_if cmd_if ();
  dotq_res_if res_if ();

  deadline_ordered_timer_event_queue_core #(
    .TABLE_DEPTH(TableDepth),
    .DELAY_BITS (DelayBits)
  ) u_top (
    .clk_i,
    .rst_ni,
    .in_i (cmd_if),
    .out_o(res_if)
  );

  // predicted table: packed, sorted in firing order
  logic [TimeW-1:0] timer_now;
  logic [IdW-1:0]   timer_next_id;
  int unsigned      timer_count;
  logic [TimeW-1:0] slot_deadline [TableDepth];
  logic [IdW-1:0]   slot_id       [TableDepth];

  timer_cmd_t  pending_cmds [$];
  result_t     expected_results [$];

  int unsigned n_pushed, n_accepted, n_results, fail_cnt;
  int unsigned n_expired, n_full, n_invalid, n_not_found;
  int unsigned issued_guess;
  int unsigned snd_idle_pct, rcv_stall_pct;
  int unsigned hold_cnt, stall_cyc;
  bit          hold_req;
  bit          cmd_taken;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void expect_result(result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic result_t wait_summary(status_e st, logic [IdW-1:0] id);
    result_t          r;
    logic [TimeW-1:0] gap;
    r = '0;
    r.status   = st;
    r.event_id = id;
    r.last     = 1'b1;
    if (timer_count == 0) begin
      r.none_pending = 1'b1;
    end else begin
      gap = slot_deadline[0] - timer_now;
      r.wait_ms = (gap > WaitMax) ? '1 : gap[DelayW-1:0];
    end
    return r;
  endfunction

  function automatic void drop_slot(int unsigned idx);
    for (int unsigned j = idx; j + 1 < timer_count; j++) begin
      slot_deadline[j] = slot_deadline[j+1];
      slot_id[j]       = slot_id[j+1];
    end
    timer_count--;
  endfunction

  function automatic void predict_timer_cmd(cmd_e c, logic [DelayW-1:0] dly,
                                            logic [IdW-1:0] tid);
    logic [TimeW-1:0] d;
    logic [TimeW-1:0] gap;
    int               p;
    result_t          r;
    d = TimeW'(dly) & ((TimeW'(1) << DelayBits) - 1);
    case (c)
      CMD_ADD: begin
        if (d == 0) begin
          expect_result(wait_summary(ST_INVALID, '0));
          n_invalid++;
        end else if (timer_count >= TableDepth) begin
          expect_result(wait_summary(ST_FULL, '0));
          n_full++;
        end else begin
          timer_next_id++;
          p = 0;
          // equal deadlines go behind the ones already queued
          while (p < timer_count && (slot_deadline[p] - timer_now) <= d) p++;
          for (int i = timer_count; i > p; i--) begin
            slot_deadline[i] = slot_deadline[i-1];
            slot_id[i]       = slot_id[i-1];
          end
          slot_deadline[p] = timer_now + d;
          slot_id[p]       = timer_next_id;
          timer_count++;
          expect_result(wait_summary(ST_OK, timer_next_id));
        end
      end
      CMD_REMOVE: begin
        p = -1;
        for (int i = 0; i < timer_count; i++) begin
          if (p < 0 && slot_id[i] == tid) p = i;
        end
        if (p >= 0) begin
          drop_slot(p);
          expect_result(wait_summary(ST_OK, tid));
        end else begin
          expect_result(wait_summary(ST_NOT_FOUND, tid));
          n_not_found++;
        end
      end
      CMD_TICK: begin
        timer_now++;
        while (timer_count > 0) begin
          gap = slot_deadline[0] - timer_now;
          if (!(gap == 0 || gap[TimeW-1])) break;
          r = '0;
          r.status   = ST_OK;
          r.event_id = slot_id[0];
          r.expired  = 1'b1;
          expect_result(r);
          n_expired++;
          drop_slot(0);
        end
        expect_result(wait_summary(ST_OK, '0));
      end
      default: expect_result(wait_summary(ST_OK, '0));
    endcase
  endfunction

  // command driver
  always @(negedge clk_i) begin
    timer_cmd_t nxt;
    if (rst_ni && (!cmd_if.valid || cmd_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        nxt = pending_cmds[0];
        pending_cmds.delete(0);
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= nxt.command;
        cmd_if.delay_ms  <= nxt.delay_ms;
        cmd_if.target_id <= nxt.target_id;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt < HoldLen) begin
      hold_cnt     <= hold_cnt + 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // monitor, prediction, checking and watchdog
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      cmd_taken <= cmd_if.valid && cmd_if.ready;
      if (cmd_if.valid && cmd_if.ready) begin
        predict_timer_cmd(cmd_e'(cmd_if.command), cmd_if.delay_ms, cmd_if.target_id);
        n_accepted++;
      end
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: event_id %0d", res_if.event_id);
          fail_cnt++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_if.status);
            fail_cnt++;
          end
          if (res_if.event_id !== want.event_id) begin
            $error("event_id: expected %0d, got %0d", want.event_id, res_if.event_id);
            fail_cnt++;
          end
          if (res_if.expired !== want.expired) begin
            $error("expired: expected %0d, got %0d", want.expired, res_if.expired);
            fail_cnt++;
          end
          if (res_if.wait_ms !== want.wait_ms) begin
            $error("wait_ms: expected %0d, got %0d", want.wait_ms, res_if.wait_ms);
            fail_cnt++;
          end
          if (res_if.none_pending !== want.none_pending) begin
            $error("none_pending: expected %0d, got %0d", want.none_pending,
                   res_if.none_pending);
            fail_cnt++;
          end
          if (res_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_if.last);
            fail_cnt++;
          end
        end
      end
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cyc = 0;
      end else if (n_pushed != n_accepted || expected_results.size() != 0) begin
        stall_cyc++;
      end
      if (stall_cyc >= WatchLimit) begin
        $display("deadline_ordered_timer_event_queue_core: mismatch");
        $finish;
      end
    end
  end

  task automatic push_cmd(cmd_e c, logic [DelayW-1:0] dly, logic [IdW-1:0] tid);
    timer_cmd_t item;
    item.command   = c;
    item.delay_ms  = dly;
    item.target_id = tid;
    pending_cmds.insert(pending_cmds.size(), item);
    n_pushed++;
  endtask

  // returns at a rising edge once every item is in and every result is out
  task automatic wait_drained();
    do @(negedge clk_i); while (n_pushed != n_accepted || expected_results.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic gen_mix(int unsigned n);
    int unsigned       r;
    logic [DelayW-1:0] d;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 42) begin
        r = $urandom_range(99);
        if (r < 70)      d = DelayW'($urandom_range(8, 1));
        else if (r < 85) d = DelayW'($urandom_range(64, 1));
        else if (r < 93) d = DelayW'($urandom());
        else             d = '0;
        push_cmd(CMD_ADD, d, $urandom());
        if (d != 0) issued_guess++;
      end else if (r < 72) begin
        push_cmd(CMD_TICK, DelayW'($urandom()), $urandom());
      end else if (r < 90) begin
        push_cmd(CMD_REMOVE, DelayW'($urandom()), $urandom_range(issued_guess, 1));
      end else if (r < 95) begin
        push_cmd(CMD_REMOVE, DelayW'($urandom()), $urandom());
      end else begin
        push_cmd(CMD_NOP, DelayW'($urandom()), $urandom());
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = CMD_NOP;
    cmd_if.delay_ms  = '0;
    cmd_if.target_id = '0;
    res_if.ready     = 1'b0;
    timer_now        = '0;
    timer_next_id    = '0;
    timer_count      = 0;
    for (int i = 0; i < TableDepth; i++) begin
      slot_deadline[i] = '0;
      slot_id[i]       = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: invalid delay, extremes, ties, unknown ids, idle command, expiry order
    push_cmd(CMD_ADD, '0, '0);
    push_cmd(CMD_ADD, 24'd1, '0);
    push_cmd(CMD_ADD, '1, '1);
    push_cmd(CMD_ADD, 24'd5, '0);
    push_cmd(CMD_ADD, 24'd5, '0);
    push_cmd(CMD_ADD, 24'd3, '0);
    push_cmd(CMD_REMOVE, '0, '1);
    push_cmd(CMD_REMOVE, '1, '0);
    push_cmd(CMD_REMOVE, '0, 32'd4);
    push_cmd(CMD_NOP, '1, '1);
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_ADD, 24'd2, '0);
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_REMOVE, '0, 32'd2);
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_ADD, 24'h555555, 32'h5555_5555);
    push_cmd(CMD_ADD, 24'hAAAAAA, 32'hAAAA_AAAA);
    push_cmd(CMD_REMOVE, '0, 32'd7);
    push_cmd(CMD_REMOVE, '0, 32'd8);
    issued_guess = 8;
    wait_drained();

    // receiver holds off first, then the table is filled past full; a tick flushes it
    hold_req = 1'b1;
    repeat (TableDepth + 2) begin
      push_cmd(CMD_ADD, 24'd1, $urandom());
      issued_guess++;
    end
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_TICK, '0, '0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 81; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 81; end
        default: begin snd_idle_pct = 26; rcv_stall_pct = 26; end
      endcase
      gen_mix(55);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d commands and %0d results: %0d expiries, %0d full-table adds,",
             n_accepted, n_results, n_expired, n_full);
    $display("%0d zero-delay adds and %0d removes of unknown ids", n_invalid, n_not_found);
    if (fail_cnt == 0) begin
      $display("deadline_ordered_timer_event_queue_core: match");
    end else begin
      $display("deadline_ordered_timer_event_queue_core: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dotq_pkg.sv
hw/rtl/dotq_if.sv
hw/rtl/dotq_cell.sv
hw/rtl/deadline_ordered_timer_event_queue_core.sv
test/tb_deadline_ordered_timer_event_queue_core.sv
